@@ hdl/mrsqe_pkg.sv @@
// Shared types, codes and constants for the Modbus RTU sensor query engine.
// No dependencies.
package mrsqe_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // command codes: three query starts, one reply byte
    localparam logic [1:0] CMD_HUMITURE = 2'd0;
    localparam logic [1:0] CMD_NOISE    = 2'd1;
    localparam logic [1:0] CMD_PM       = 2'd2;
    localparam logic [1:0] CMD_REPLY    = 2'd3;

    // register indexes of the config port
    localparam logic [2:0] REG_DEV_ADDR  = 3'd0;
    localparam logic [2:0] REG_FUNC      = 3'd1;
    localparam logic [2:0] REG_ADDR_HIGH = 3'd2;
    localparam logic [2:0] REG_ADDR_LOW  = 3'd3;
    localparam logic [2:0] REG_CNT_HIGH  = 3'd4;
    localparam logic [2:0] REG_CNT_LOW   = 3'd5;

    localparam logic [0:0] KIND_TX      = 1'b0;
    localparam logic [0:0] KIND_READING = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ_CRC,
        S_REQ_EMIT,
        S_RX_CRC,
        S_READ
    } t_state;

    function automatic logic [7:0] query_offset(input logic [1:0] q);
        case (q)
            CMD_NOISE: query_offset = 8'd2;
            CMD_PM:    query_offset = 8'd3;
            default:   query_offset = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] query_count(input logic [1:0] q);
        case (q)
            CMD_NOISE: query_count = 8'd1;
            default:   query_count = 8'd2;
        endcase
    endfunction

    // index of the first reply CRC byte (reply length minus two)
    function automatic logic [3:0] reply_crc_index(input logic [1:0] q);
        case (q)
            CMD_NOISE: reply_crc_index = 4'd5;
            default:   reply_crc_index = 4'd7;
        endcase
    endfunction

endpackage

@@ hdl/modbus_rtu_sensor_query_engine_unit.sv @@
// Modbus RTU master query engine: request build with CRC-16/Modbus, reply check.
// Depends on mrsqe_pkg. One bit-serial CRC unit is shared by request and reply.
// Start item: CRC over 6 bytes bit by bit, then 8 tx beats, one per cycle while the output is free.
// Reply byte: taken while idle; bytes ahead of the reply CRC are then folded in bit by bit.
// Final reply byte: one reading beat, built in the read state and registered when the output is free.
// Input stall is high while the sequencer works.
// Synchronous active-low reset: config to defaults, no query pending, output empty.
module modbus_rtu_sensor_query_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic        o_status,
    output logic [1:0]  o_query_done,
    output logic signed [15:0] o_value_a,
    output logic signed [15:0] o_value_b
);
    import mrsqe_pkg::*;

    t_state r_state, n_state;

    logic [7:0]  r_cfg [6];
    logic        r_pending, n_pending;
    logic [1:0]  r_query, n_query;
    logic [3:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [31:0] r_data, n_data;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_rx, n_rx;
    logic [2:0]  r_idx, n_idx;
    logic [2:0]  r_bit, n_bit;

    logic        r_out_valid, n_out_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_tx, n_tx;
    logic        r_last, n_last;
    logic        r_status, n_status;
    logic [1:0]  r_qdone, n_qdone;
    logic [15:0] r_va, n_va;
    logic [15:0] r_vb, n_vb;

    logic        in_acc;
    logic        out_free;
    logic [7:0]  req_byte;
    logic [7:0]  feed;
    logic [15:0] crc_in;
    logic [15:0] crc_step;
    logic        crc_good;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_tx_byte    = r_tx;
    assign o_last       = r_last;
    assign o_status     = r_status;
    assign o_query_done = r_qdone;
    assign o_value_a    = r_va;
    assign o_value_b    = r_vb;

    always_comb begin
        case (r_idx)
            3'd0:    req_byte = r_cfg[REG_DEV_ADDR];
            3'd1:    req_byte = r_cfg[REG_FUNC];
            3'd2:    req_byte = r_cfg[REG_ADDR_HIGH];
            3'd3:    req_byte = r_cfg[REG_ADDR_LOW] + query_offset(r_query);
            3'd4:    req_byte = r_cfg[REG_CNT_HIGH];
            3'd5:    req_byte = r_cfg[REG_CNT_LOW] + query_count(r_query);
            3'd6:    req_byte = r_crc[7:0];
            default: req_byte = r_crc[15:8];
        endcase
    end

    // shared CRC unit: byte folded in on bit 0, one shift/xor per cycle
    assign feed     = (r_state == S_RX_CRC) ? r_rx : req_byte;
    assign crc_in   = (r_bit == 3'd0) ? (r_crc ^ {8'h00, feed}) : r_crc;
    assign crc_step = crc_in[0] ? ((crc_in >> 1) ^ CRC_POLY) : (crc_in >> 1);
    assign crc_good = ({r_rx, r_first} == r_crc);

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_query     = r_query;
        n_count     = r_count;
        n_crc       = r_crc;
        n_data      = r_data;
        n_first     = r_first;
        n_rx        = r_rx;
        n_idx       = r_idx;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_tx        = r_tx;
        n_last      = r_last;
        n_status    = r_status;
        n_qdone     = r_qdone;
        n_va        = r_va;
        n_vb        = r_vb;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command != CMD_REPLY) begin
                        n_query   = i_command;
                        n_pending = 1'b1;
                        n_count   = 4'd0;
                        n_crc     = CRC_INIT;
                        n_data    = 32'd0;
                        n_first   = 8'd0;
                        n_idx     = 3'd0;
                        n_bit     = 3'd0;
                        n_state   = S_REQ_CRC;
                    end else if (r_pending) begin
                        n_rx    = i_rx_byte;
                        n_count = r_count + 4'd1;
                        if (r_count < reply_crc_index(r_query)) begin
                            if (r_count >= 4'd3 && r_count <= 4'd6) begin
                                n_data = {r_data[23:0], i_rx_byte};
                            end
                            n_bit   = 3'd0;
                            n_state = S_RX_CRC;
                        end else if (r_count == reply_crc_index(r_query)) begin
                            n_first = i_rx_byte;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_REQ_CRC: begin
                n_crc = crc_step;
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    if (r_idx == 3'd5) begin
                        n_idx   = 3'd0;
                        n_state = S_REQ_EMIT;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            S_REQ_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TX;
                    n_tx        = req_byte;
                    n_last      = (r_idx == 3'd7);
                    n_status    = 1'b0;
                    n_qdone     = r_query;
                    n_va        = 16'd0;
                    n_vb        = 16'd0;
                    n_idx       = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_crc   = CRC_INIT;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RX_CRC: begin
                n_crc = crc_step;
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_READING;
                    n_tx        = 8'd0;
                    n_last      = 1'b1;
                    n_status    = !crc_good;
                    n_qdone     = r_query;
                    n_va        = 16'd0;
                    n_vb        = 16'd0;
                    if (crc_good) begin
                        if (r_query == CMD_NOISE) begin
                            n_va = r_data[15:0];
                        end else begin
                            n_va = r_data[31:16];
                            n_vb = r_data[15:0];
                        end
                    end
                    n_pending = 1'b0;
                    n_count   = 4'd0;
                    n_crc     = CRC_INIT;
                    n_data    = 32'd0;
                    n_first   = 8'd0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_query     <= CMD_HUMITURE;
            r_count     <= 4'd0;
            r_crc       <= CRC_INIT;
            r_data      <= 32'd0;
            r_first     <= 8'd0;
            r_idx       <= 3'd0;
            r_bit       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_query     <= n_query;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_data      <= n_data;
            r_first     <= n_first;
            r_idx       <= n_idx;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_rx     <= n_rx;
        r_kind   <= n_kind;
        r_tx     <= n_tx;
        r_last   <= n_last;
        r_status <= n_status;
        r_qdone  <= n_qdone;
        r_va     <= n_va;
        r_vb     <= n_vb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_DEV_ADDR]  <= 8'd1;
            r_cfg[REG_FUNC]      <= 8'd3;
            r_cfg[REG_ADDR_HIGH] <= 8'd0;
            r_cfg[REG_ADDR_LOW]  <= 8'd0;
            r_cfg[REG_CNT_HIGH]  <= 8'd0;
            r_cfg[REG_CNT_LOW]   <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DEV_ADDR:  r_cfg[REG_DEV_ADDR]  <= i_cfg_data;
                REG_FUNC:      r_cfg[REG_FUNC]      <= i_cfg_data;
                REG_ADDR_HIGH: r_cfg[REG_ADDR_HIGH] <= i_cfg_data;
                REG_ADDR_LOW:  r_cfg[REG_ADDR_LOW]  <= i_cfg_data;
                REG_CNT_HIGH:  r_cfg[REG_CNT_HIGH]  <= i_cfg_data;
                REG_CNT_LOW:   r_cfg[REG_CNT_LOW]   <= i_cfg_data;
                default: ;  // unmapped index, write ignored
            endcase
        end
    end

endmodule

@@ test/tb.sv @@
// Testbench for modbus_rtu_sensor_query_engine_unit: request bytes and sensor readings
// are checked beat by beat against an in-bench model of the query engine.
// Depends on mrsqe_pkg and the engine RTL only.
module tb;

    import mrsqe_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 40;

    // per-query tables, indexed by start command
    localparam logic [2:0][7:0] ADDR_STEP  = {8'd3, 8'd2, 8'd0};
    localparam logic [2:0][7:0] COUNT_STEP = {8'd2, 8'd1, 8'd2};
    localparam logic [2:0][3:0] REPLY_LEN  = {4'd9, 4'd7, 4'd9};

    typedef struct packed {
        logic [0:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        status;
        logic [1:0]  query;
        logic [15:0] value_a;
        logic [15:0] value_b;
    } t_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_command;
    logic [7:0]         i_rx_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_kind;
    logic [7:0]         o_tx_byte;
    logic               o_last;
    logic               o_status;
    logic [1:0]         o_query_done;
    logic signed [15:0] o_value_a;
    logic signed [15:0] o_value_b;

    // engine model state
    logic [7:0]  cfg_shadow [6];
    logic        query_open;
    logic [1:0]  open_query;
    logic [3:0]  reply_pos;
    logic [15:0] reply_crc_acc;
    logic [31:0] reply_word;
    logic [7:0]  reply_crc_lo;

    t_beat sensor_beats_due [$];

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  idle_cycles  = 0;
    int  hold_off_len = 0;
    bit  send_no_gaps = 1'b0;
    bit  recv_no_gaps = 1'b0;

    modbus_rtu_sensor_query_engine_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_query_done (o_query_done),
        .o_value_a    (o_value_a),
        .o_value_b    (o_value_b)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic clear_reply_state();
        reply_pos     = '0;
        reply_crc_acc = CRC_INIT;
        reply_word    = '0;
        reply_crc_lo  = '0;
    endtask

    task automatic reset_engine_model();
        cfg_shadow[REG_DEV_ADDR]  = 8'd1;
        cfg_shadow[REG_FUNC]      = 8'd3;
        cfg_shadow[REG_ADDR_HIGH] = 8'd0;
        cfg_shadow[REG_ADDR_LOW]  = 8'd0;
        cfg_shadow[REG_CNT_HIGH]  = 8'd0;
        cfg_shadow[REG_CNT_LOW]   = 8'd0;
        query_open = 1'b0;
        open_query = CMD_HUMITURE;
        clear_reply_state();
    endtask

    // queue the beats one accepted command produces
    task automatic predict_query_beats(input logic [1:0] cmd, input logic [7:0] rx);
        logic [7:0]  req [8];
        logic [15:0] crc;
        logic [15:0] got;
        logic [3:0]  crc_at;
        t_beat       b;
        if (cmd != CMD_REPLY) begin
            for (int i = 0; i < 6; i++)
                req[i] = cfg_shadow[i];
            req[REG_ADDR_LOW] = req[REG_ADDR_LOW] + ADDR_STEP[cmd];
            req[REG_CNT_LOW]  = req[REG_CNT_LOW] + COUNT_STEP[cmd];
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++)
                crc = crc16_modbus(crc, req[i]);
            req[6] = crc[7:0];
            req[7] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
                b = '0;
                b.kind    = KIND_TX;
                b.tx_byte = req[i];
                b.last    = (i == 7);
                b.query   = cmd;
                sensor_beats_due.push_back(b);
            end
            query_open = 1'b1;
            open_query = cmd;
            clear_reply_state();
        end else if (query_open) begin
            crc_at = REPLY_LEN[open_query] - 4'd2;
            if (reply_pos < crc_at) begin
                reply_crc_acc = crc16_modbus(reply_crc_acc, rx);
                if (reply_pos >= 3 && reply_pos <= 6)
                    reply_word = {reply_word[23:0], rx};
                reply_pos = reply_pos + 4'd1;
            end else if (reply_pos == crc_at) begin
                reply_crc_lo = rx;
                reply_pos    = reply_pos + 4'd1;
            end else begin
                got = {rx, reply_crc_lo};
                b = '0;
                b.kind   = KIND_READING;
                b.last   = 1'b1;
                b.status = (got != reply_crc_acc);
                b.query  = open_query;
                if (got == reply_crc_acc) begin
                    if (open_query == CMD_NOISE) begin
                        b.value_a = reply_word[15:0];
                    end else begin
                        b.value_a = reply_word[31:16];
                        b.value_b = reply_word[15:0];
                    end
                end
                sensor_beats_due.push_back(b);
                query_open = 1'b0;
                clear_reply_state();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_REPORTS)
            $display("mismatch on %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
        fail_count++;
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx);
        int gap;
        gap = send_no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_command  = cmd;
        i_rx_byte  = rx;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd != CMD_REPLY || query_open)
            items_sent++;
        predict_query_beats(cmd, rx);
    endtask

    // reply frame: addr, func, byte count, data, CRC low/high; a bad frame gets one bit flipped
    task automatic send_reply(input logic [1:0] q, input logic [15:0] va, input logic [15:0] vb,
                              input bit bad_crc, input int n_send);
        logic [7:0]  frame [9];
        logic [15:0] crc;
        int          n;
        n = int'(REPLY_LEN[q]);
        frame[0] = 8'($urandom);
        frame[1] = 8'($urandom);
        frame[2] = (q == CMD_NOISE) ? 8'd2 : 8'd4;
        frame[3] = va[15:8];
        frame[4] = va[7:0];
        frame[5] = vb[15:8];
        frame[6] = vb[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < n - 2; i++)
            crc = crc16_modbus(crc, frame[i]);
        frame[n - 2] = crc[7:0];
        frame[n - 1] = crc[15:8];
        if (bad_crc)
            frame[$urandom_range(0, n - 1)] ^= (8'h01 << $urandom_range(0, 7));
        for (int i = 0; i < n && i < n_send; i++)
            send_item(CMD_REPLY, frame[i]);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_shadow[idx] = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] dev, input logic [7:0] func,
                                input logic [7:0] addr_hi, input logic [7:0] addr_lo,
                                input logic [7:0] cnt_hi, input logic [7:0] cnt_lo);
        write_reg(REG_DEV_ADDR, dev);
        write_reg(REG_FUNC, func);
        write_reg(REG_ADDR_HIGH, addr_hi);
        write_reg(REG_ADDR_LOW, addr_lo);
        write_reg(REG_CNT_HIGH, cnt_hi);
        write_reg(REG_CNT_LOW, cnt_lo);
    endtask

    // wait until every queued beat is out, then let a trailing reply byte settle
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sensor_beats_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_directed_defaults();
        send_item(CMD_REPLY, 8'hFF);    // nothing pending: dropped
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_HUMITURE, 8'h00);
        send_reply(CMD_HUMITURE, 16'h7FFF, 16'h8000, 1'b0, 16);
        send_item(CMD_PM, 8'hA5);
        send_reply(CMD_PM, 16'h1111, 16'h2222, 1'b0, 2);
        send_item(CMD_NOISE, 8'h5A);    // restarts reception mid-reply
        send_reply(CMD_NOISE, 16'h0321, 16'h7777, 1'b0, 16);
        send_item(CMD_PM, 8'h00);
        send_reply(CMD_PM, 16'hFFFF, 16'h0000, 1'b0, 16);
        send_item(CMD_HUMITURE, 8'h00);
        send_reply(CMD_HUMITURE, 16'h1234, 16'h5678, 1'b1, 16);
        drain();
    endtask

    task automatic run_each_query();
        for (int q = CMD_HUMITURE; q <= CMD_PM; q++) begin
            send_item(2'(q), 8'($urandom));
            send_reply(2'(q), pick_value(), pick_value(), 1'b0, 16);
        end
        drain();
    endtask

    task automatic test_register_extremes();
        // offsets and counts wrap past 0xFF
        apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_each_query();
        apply_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        run_each_query();
        apply_config(8'hAA, 8'h55, 8'h80, 8'hFE, 8'h7F, 8'hFE);
        run_each_query();
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        int q;
        for (int phase = 0; phase < 4; phase++) begin
            apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            send_no_gaps = (phase == 2);
            recv_no_gaps = (phase == 2);
            target = items_sent + 12;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                q    = $urandom_range(CMD_HUMITURE, CMD_PM);
                if (pick < 72) begin
                    send_item(2'(q), 8'($urandom));
                    send_reply(2'(q), pick_value(), pick_value(),
                               $urandom_range(0, 9) == 0, 16);
                end else if (pick < 86) begin
                    send_item(2'(q), 8'($urandom));
                    send_reply(2'(q), pick_value(), pick_value(), 1'b0,
                               $urandom_range(0, 8));
                end else begin
                    send_item(CMD_REPLY, 8'($urandom));
                end
            end
            drain();
        end
        send_no_gaps = 1'b0;
        recv_no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int q;
        send_no_gaps = 1'b1;
        hold_off_len = 120;
        repeat (3) begin
            q = $urandom_range(CMD_HUMITURE, CMD_PM);
            send_item(2'(q), 8'($urandom));
            send_reply(2'(q), pick_value(), pick_value(), 1'b0, 16);
        end
        send_no_gaps = 1'b0;
        drain();
    endtask

    // result side: random stall before each beat, plus a long hold-off on request
    initial begin : result_side
        int gap;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len > 0) begin
                i_out_stall = 1'b1;
                repeat (hold_off_len) @(negedge i_clk);
                hold_off_len = 0;
            end
            gap = recv_no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : check_beats
        t_beat seen;
        t_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = {o_kind, o_tx_byte, o_last, o_status, o_query_done, o_value_a, o_value_b};
            if (sensor_beats_due.size() == 0) begin
                report_mismatch("beat with nothing expected", 32'(seen.tx_byte), 0);
            end else begin
                want = sensor_beats_due.pop_front();
                if (seen.kind != want.kind)       report_mismatch("kind", 32'(seen.kind),
                                                                   32'(want.kind));
                if (seen.tx_byte != want.tx_byte) report_mismatch("tx_byte", 32'(seen.tx_byte),
                                                                   32'(want.tx_byte));
                if (seen.last != want.last)       report_mismatch("last", 32'(seen.last),
                                                                   32'(want.last));
                if (seen.status != want.status)   report_mismatch("status", 32'(seen.status),
                                                                   32'(want.status));
                if (seen.query != want.query)     report_mismatch("query_done", 32'(seen.query),
                                                                   32'(want.query));
                if (seen.value_a != want.value_a) report_mismatch("value_a", 32'(seen.value_a),
                                                                   32'(want.value_a));
                if (seen.value_b != want.value_b) report_mismatch("value_b", 32'(seen.value_b),
                                                                   32'(want.value_b));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_DEV_ADDR;
        i_cfg_data  = 8'h00;
        i_in_valid  = 1'b0;
        i_command   = CMD_HUMITURE;
        i_rx_byte   = 8'h00;
        reset_engine_model();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_defaults();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        drain();

        if (sensor_beats_due.size() != 0)
            report_mismatch("beats never produced", sensor_beats_due.size(), 0);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
